### hdl/cpd_pkg.sv
package cpd_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int KIND_W = 2;
    localparam int PHASE_W = 3;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_CMD_LO  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD_HI  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CHK_LO  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_CHK_HI  = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] out_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [WORD_W-1:0] frame_command;
        logic [WORD_W-1:0] frame_length;
        logic [WORD_W-1:0] sent_checksum;
        logic              end_of_frame;
    } t_result;

endpackage

### hdl/cpd_parser.sv
module cpd_parser
    import cpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_low_hold, n_low_hold;
    logic [WORD_W-1:0]  r_sum, n_sum;
    logic [WORD_W-1:0]  r_command, n_command;
    logic [WORD_W-1:0]  r_length, n_length;
    logic [WORD_W-1:0]  r_count, n_count;

    logic [WORD_W-1:0] sum_add;
    logic [WORD_W-1:0] joined;
    logic [WORD_W-1:0] count_inc;

    assign sum_add   = r_sum + {{(WORD_W-BYTE_W){1'b0}}, i_rx_byte};
    assign joined    = {i_rx_byte, r_low_hold};
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_low_hold = r_low_hold;
        n_sum      = r_sum;
        n_command  = r_command;
        n_length   = r_length;
        n_count    = r_count;

        o_res_valid          = 1'b0;
        o_res.out_kind       = KIND_DATA;
        o_res.data_byte      = '0;
        o_res.frame_command  = r_command;
        o_res.frame_length   = r_length;
        o_res.sent_checksum  = '0;
        o_res.end_of_frame   = 1'b0;

        unique case (r_phase)
            PH_CMD_HI: begin
                n_sum     = sum_add;
                n_command = joined;
                n_phase   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_sum      = sum_add;
                n_low_hold = i_rx_byte;
                n_phase    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_sum    = sum_add;
                n_length = joined;
                n_count  = '0;
                n_phase  = (joined == '0) ? PH_CHK_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum   = sum_add;
                n_count = count_inc;
                if (count_inc >= r_length) begin
                    n_phase = PH_CHK_LO;
                end
                o_res_valid     = 1'b1;
                o_res.data_byte = i_rx_byte;
            end
            PH_CHK_LO: begin
                n_low_hold = i_rx_byte;
                n_phase    = PH_CHK_HI;
            end
            PH_CHK_HI: begin
                o_res_valid         = 1'b1;
                o_res.out_kind      = (joined == r_sum) ? KIND_GOOD : KIND_MISMATCH;
                o_res.sent_checksum = joined;
                o_res.end_of_frame  = 1'b1;
                n_sum               = '0;
                n_phase             = PH_CMD_LO;
            end
            default: begin
                // command low byte, also the landing spot for the unused code
                n_sum      = {{(WORD_W-BYTE_W){1'b0}}, i_rx_byte};
                n_low_hold = i_rx_byte;
                n_count    = '0;
                n_phase    = PH_CMD_HI;
            end
        endcase

        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CMD_LO;
            r_low_hold <= '0;
            r_sum      <= '0;
            r_command  <= '0;
            r_length   <= '0;
            r_count    <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_low_hold <= n_low_hold;
            r_sum      <= n_sum;
            r_command  <= n_command;
            r_length   <= n_length;
            r_count    <= n_count;
        end
    end

endmodule

### hdl/cpd_out_skid.sv
module cpd_out_skid
    import cpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_full
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;
    assign o_full   = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

### hdl/checksummed_packet_deframer.sv
// Deframer for length-prefixed link frames with a 16-bit additive checksum.
// Input channel: one link byte per word on i_rx_byte, qualified by i_valid;
// the word is taken at a clock edge where i_valid is high and o_stall is low.
// Frame: command (lo, hi), length (lo, hi), payload bytes, checksum (lo, hi).
// Output channel: o_valid / i_stall. Each payload byte gives one word with
// out_kind 0; the checksum high byte gives a status word (1 good, 2 mismatch)
// with end_of_frame set and the received checksum. Header and checksum low
// bytes give no output word.
// An output word reaches o_* from the output register, via the skid entry
// first if the receiver stalls. Throughput: one byte per cycle, sustained,
// as long as the receiver keeps up. An output register plus a one-entry
// skid buffer separate the two channels, so o_stall is a register output.
// When the receiver stalls, the output word holds; one more result fits in
// the skid entry, after which o_stall rises until the output drains.
// Reset (i_rst_n low, synchronous) clears the running sum, the header words
// and both output stages; the block then waits for a command low byte.
module checksummed_packet_deframer
    import cpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [KIND_W-1:0]   o_out_kind,
    output logic [BYTE_W-1:0]   o_data_byte,
    output logic [WORD_W-1:0]   o_frame_command,
    output logic [WORD_W-1:0]   o_frame_length,
    output logic [WORD_W-1:0]   o_sent_checksum,
    output logic                o_end_of_frame
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    skid_full;

    // skid entry occupied means no room for another result
    assign o_stall = skid_full;
    assign accept  = i_valid && !skid_full;

    cpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cpd_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .o_full      (skid_full)
    );

    assign o_out_kind      = out_res.out_kind;
    assign o_data_byte     = out_res.data_byte;
    assign o_frame_command = out_res.frame_command;
    assign o_frame_length  = out_res.frame_length;
    assign o_sent_checksum = out_res.sent_checksum;
    assign o_end_of_frame  = out_res.end_of_frame;

endmodule
